// ===== rtl/skts_pkg.sv =====
package skts_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 48;
    localparam int MODE_W  = 3;
    localparam int POS_W   = 7;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BSRCH  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LSRCH  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CHECK  = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  entry_value;
    } skts_in_t;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  position;
        logic [KEY_W-1:0]  found_value;
        logic              is_sorted;
        logic [POS_W-1:0]  entry_count;
        logic              full_error;
    } skts_out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_CLEAR,
        OP_APPEND,
        OP_BS_INIT,
        OP_BS_PROBE,
        OP_BS_STEP,
        OP_LS_INIT,
        OP_LS_PROBE,
        OP_LS_STEP,
        OP_FINISH
    } skts_op_t;

    typedef struct packed {
        skts_op_t op;
    } skts_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              bs_active;
        logic              ls_active;
        logic              out_free;
    } skts_status_t;

endpackage

// ===== rtl/skts_ram.sv =====
module skts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/skts_ctrl.sv =====
module skts_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  skts_pkg::skts_status_t status,
    output skts_pkg::skts_cmd_t    cmd
);
    import skts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_BS_PROBE,
        S_BS_CMP,
        S_LS_PROBE,
        S_LS_CMP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (status.mode)
                    MODE_CLEAR:
                    begin
                        cmd.op     = OP_CLEAR;
                        state_next = S_DONE;
                    end
                    MODE_APPEND:
                    begin
                        cmd.op     = OP_APPEND;
                        state_next = S_DONE;
                    end
                    MODE_BSRCH:
                    begin
                        cmd.op     = OP_BS_INIT;
                        state_next = S_BS_PROBE;
                    end
                    MODE_LSRCH:
                    begin
                        cmd.op     = OP_LS_INIT;
                        state_next = S_LS_PROBE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_BS_PROBE:
            begin
                if (status.bs_active)
                begin
                    cmd.op     = OP_BS_PROBE;
                    state_next = S_BS_CMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_BS_CMP:
            begin
                cmd.op     = OP_BS_STEP;
                state_next = S_BS_PROBE;
            end
            S_LS_PROBE:
            begin
                if (status.ls_active)
                begin
                    cmd.op     = OP_LS_PROBE;
                    state_next = S_LS_CMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LS_CMP:
            begin
                cmd.op     = OP_LS_STEP;
                state_next = S_LS_PROBE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/skts_dp.sv =====
module skts_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  skts_pkg::skts_in_t     in_item,
    input  skts_pkg::skts_cmd_t    cmd,
    output skts_pkg::skts_status_t status,
    output logic                   out_valid,
    input  logic                   out_stall,
    output skts_pkg::skts_out_t    out_item
);
    import skts_pkg::*;

    // request
    skts_in_t         req_reg;

    // table bookkeeping
    logic [CNT_W-1:0] count_reg;
    logic             sorted_reg;
    logic [KEY_W-1:0] last_key_reg;

    // search state
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] hi_reg;
    logic [CNT_W-1:0] mid_reg;
    logic [CNT_W-1:0] idx_reg;

    // result under construction
    logic             found_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [KEY_W-1:0] fval_reg;
    logic             ferr_reg;

    // output register
    logic             out_valid_reg;
    skts_out_t        out_reg;

    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid_next;
    logic             table_full;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [KEY_W-1:0] rd_key;
    logic [KEY_W-1:0] rd_val;

    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_next   = mid_sum[CNT_W:1];
    assign table_full = (count_reg == CNT_W'(DEPTH));
    assign wr_en      = (cmd.op == OP_APPEND) && !table_full;
    assign rd_addr    = (cmd.op == OP_BS_PROBE) ? mid_next[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    skts_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (req_reg.key),
        .raddr (rd_addr),
        .rdata (rd_key)
    );

    skts_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_val_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (req_reg.entry_value),
        .raddr (rd_addr),
        .rdata (rd_val)
    );

    assign status.mode      = req_reg.mode;
    assign status.bs_active = (lo_reg < hi_reg) && !found_reg;
    assign status.ls_active = (idx_reg < count_reg) && !found_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sorted_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_CLEAR:
                begin
                    count_reg  <= '0;
                    sorted_reg <= 1'b1;
                end
                OP_APPEND:
                begin
                    if (!table_full)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        if ((count_reg != '0) && (last_key_reg > req_reg.key))
                        begin
                            sorted_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (cmd.op == OP_FINISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                req_reg   <= in_item;
                found_reg <= 1'b0;
                pos_reg   <= '0;
                fval_reg  <= '0;
                ferr_reg  <= 1'b0;
            end
            OP_APPEND:
            begin
                if (table_full)
                begin
                    ferr_reg <= 1'b1;
                end
                else
                begin
                    pos_reg      <= count_reg;
                    last_key_reg <= req_reg.key;
                end
            end
            OP_BS_INIT:
            begin
                lo_reg <= '0;
                hi_reg <= count_reg;
            end
            OP_BS_PROBE:
            begin
                mid_reg <= mid_next;
            end
            OP_BS_STEP:
            begin
                if (req_reg.key > rd_key)
                begin
                    lo_reg  <= mid_reg + CNT_W'(1);
                    pos_reg <= mid_reg + CNT_W'(1);
                end
                else if (req_reg.key < rd_key)
                begin
                    hi_reg  <= mid_reg;
                    pos_reg <= mid_reg;
                end
                else
                begin
                    found_reg <= 1'b1;
                    pos_reg   <= mid_reg;
                    fval_reg  <= rd_val;
                end
            end
            OP_LS_INIT:
            begin
                idx_reg <= '0;
            end
            OP_LS_STEP:
            begin
                if (rd_key == req_reg.key)
                begin
                    found_reg <= 1'b1;
                    pos_reg   <= idx_reg;
                    fval_reg  <= rd_val;
                end
                else
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
            OP_FINISH:
            begin
                out_reg.found       <= found_reg;
                out_reg.position    <= POS_W'(pos_reg);
                out_reg.found_value <= fval_reg;
                out_reg.is_sorted   <= sorted_reg;
                out_reg.entry_count <= POS_W'(count_reg);
                out_reg.full_error  <= ferr_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/sorted_key_table_search_unit.sv =====
// Sorted key table search unit.
// Input channel (in_valid / in_stall / in_item): one request per item, selected
// by mode: clear, append a key/value pair, binary search, linear search, or
// sortedness check. Output channel (out_valid / out_stall / out_item): exactly
// one result item per request, in request order.
// A binary search makes at most log2(count) + 1 probes; a linear search
// examines the entries in order until the first match. Each probe has two
// steps: the address is presented to the key and value memories, then the
// registered read data is compared.
// One request is worked on at a time; in_stall is high from the cycle after
// acceptance until the result has been moved into the output register. The
// next item can be taken as soon as the result is registered, even while it
// waits there.
// When out_stall is high the result holds in the output register and a
// finished request waits until the register frees up.
// Reset empties the table (entry count zero, sorted flag set) and drops any
// pending result. No memory clearing pass is needed.
module sorted_key_table_search_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  skts_pkg::skts_in_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output skts_pkg::skts_out_t out_item
);
    import skts_pkg::*;

    skts_cmd_t    cmd;
    skts_status_t status;

    // sequencing: one command per cycle
    skts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // table memories, search registers and output register
    skts_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

`ifndef NO_ASSERTIONS
    // the table never reports more entries than it can hold
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.entry_count <= POS_W'(DEPTH)))
        else $error("entry count exceeds table depth");

    // a miss carries a zero value
    a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.found) |-> (out_item.found_value == '0))
        else $error("found_value nonzero without a match");

    // a refused append only happens on a full table
    a_full_err : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.full_error)
            |-> ((out_item.entry_count == POS_W'(DEPTH)) && !out_item.found))
        else $error("full_error with table not full");

    // an accepted request blocks the input until it is finished
    a_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accepting a request");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import skts_pkg::*;

    localparam int ITEMS = 1300;
    localparam int TAIL_ITEMS = 120;          // no idling once fewer than this many are left to send
    localparam int HOLD_AFTER = 300;          // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_REPORTS = 10;
    localparam logic [MODE_W-1:0] MODE_LAST = '1;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    skts_in_t  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    skts_out_t out_item;

    // Shadow copy of the table, kept in step with the items accepted by the block.
    logic [KEY_W-1:0] tbl_key [DEPTH];
    logic [KEY_W-1:0] tbl_val [DEPTH];
    int               tbl_cnt = 0;

    skts_in_t  request_q [$];           // items still to be offered
    skts_out_t expected_results [$];    // predicted results, oldest first
    logic [KEY_W-1:0] seq_keys [$];     // keys appended by the sequence being built

    int mismatches = 0;
    int results_seen = 0;
    int gap_left, stall_left, hold_left;
    bit hold_done;
    int gap_pct, stall_pct;
    bit calm_tail;
    int cyc;

    sorted_key_table_search_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Apply one request to the shadow table and return the result it must produce.
    function automatic skts_out_t serve_request(skts_in_t req);
        skts_out_t res;
        int lo, hi, mid, at;
        bit hit;
        res = '0;
        case (req.mode)
            MODE_CLEAR:
                tbl_cnt = 0;
            MODE_APPEND:
                if (tbl_cnt < DEPTH)
                begin
                    tbl_key[tbl_cnt] = req.key;
                    tbl_val[tbl_cnt] = req.entry_value;
                    res.position = tbl_cnt[POS_W-1:0];
                    tbl_cnt++;
                end
                else
                    res.full_error = 1'b1;
            MODE_BSRCH:
            begin
                // Halve the range whether or not the keys are in order; a miss
                // leaves the last moved bound as the insertion index.
                lo = 0;
                hi = tbl_cnt;
                at = 0;
                mid = 0;
                hit = 1'b0;
                while (lo < hi && !hit)
                begin
                    mid = (lo + hi) / 2;
                    if (req.key > tbl_key[mid])
                    begin
                        lo = mid + 1;
                        at = lo;
                    end
                    else if (req.key < tbl_key[mid])
                    begin
                        hi = mid;
                        at = hi;
                    end
                    else
                    begin
                        hit = 1'b1;
                        at = mid;
                    end
                end
                res.position = at[POS_W-1:0];
                if (hit)
                begin
                    res.found = 1'b1;
                    res.found_value = tbl_val[mid];
                end
            end
            MODE_LSRCH:
                for (int i = 0; i < tbl_cnt && !res.found; i++)
                    if (tbl_key[i] == req.key)
                    begin
                        res.found = 1'b1;
                        res.position = i[POS_W-1:0];
                        res.found_value = tbl_val[i];
                    end
            default:
                ;   // sortedness check and unused modes change nothing
        endcase
        res.is_sorted = 1'b1;
        for (int i = 1; i < tbl_cnt; i++)
            if (tbl_key[i-1] > tbl_key[i])
                res.is_sorted = 1'b0;
        res.entry_count = tbl_cnt[POS_W-1:0];
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[KEY_W-1:0];
    endfunction

    // Search key: mostly stored keys and their neighbors, else extremes or noise.
    function automatic logic [KEY_W-1:0] probe_key();
        int r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 9);
        if (seq_keys.size() != 0 && r < 7)
        begin
            k = seq_keys[$urandom_range(0, seq_keys.size() - 1)];
            if (r == 5)
                k = k + 1'b1;
            else if (r == 6)
                k = k - 1'b1;
            return k;
        end
        if (r == 7)
            return $urandom_range(0, 1) ? KEY_MAX : '0;
        return rand_key();
    endfunction

    function automatic void queue_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                          logic [KEY_W-1:0] entry_value);
        skts_in_t req;
        req.mode = mode;
        req.key = key;
        req.entry_value = entry_value;
        request_q.push_back(req);
    endfunction

    function automatic int pick_idle_rate();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 8;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    // Report a field that does not match; past the first few, only count.
    task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on result %0d, %s: expected %0h, got %0h",
                         results_seen, field, want, got);
        end
    endtask

    // Sender: offer the queued items in order. Hold a stalled item unchanged,
    // and once it is taken, predict its result at that very edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(serve_request(in_item));
            if (in_valid && in_stall)
                ;   // hold the item until the block takes it
            else if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (request_q.size() == 0)
                in_valid <= 1'b0;
            else if (!calm_tail && hold_left == 0 && $urandom_range(0, 99) < gap_pct)
            begin
                // start an idle burst
                in_valid <= 1'b0;
                gap_left <= $urandom_range(0, 18);
            end
            else
            begin
                in_valid <= 1'b1;
                in_item <= request_q.pop_front();
            end
        end
    end

    // Receiver: stall in random bursts, or solid through the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_left != 0)
            out_stall <= 1'b1;
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!calm_tail && $urandom_range(0, 99) < stall_pct)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 18);
        end
        else
            out_stall <= 1'b0;
    end

    // Long hold-off, once: the sender keeps offering, so the output register
    // and the request in flight fill up and the block must stall its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Periodically vary how busy both sides are; go quiet at the end.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc <= 0;
            gap_pct <= 0;
            stall_pct <= 0;
            calm_tail <= 1'b0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (cyc % 400 == 0)
            begin
                gap_pct <= pick_idle_rate();
                stall_pct <= pick_idle_rate();
            end
            calm_tail <= request_q.size() < TAIL_ITEMS;
        end
    end

    // Monitor: match every delivered result against the oldest prediction.
    always @(posedge clk)
    begin
        skts_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result %0d: %0h", results_seen, out_item);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("found", 64'(want.found), 64'(out_item.found));
                check_field("position", 64'(want.position), 64'(out_item.position));
                check_field("found_value", 64'(want.found_value),
                            64'(out_item.found_value));
                check_field("is_sorted", 64'(want.is_sorted), 64'(out_item.is_sorted));
                check_field("entry_count", 64'(want.entry_count),
                            64'(out_item.entry_count));
                check_field("full_error", 64'(want.full_error),
                            64'(out_item.full_error));
            end
            results_seen <= results_seen + 1;
        end
    end

    initial
    begin
        int n, nq, kind, r;
        logic [KEY_W-1:0] k, step_cap;
        logic [MODE_W-1:0] mode;

        // Directed: empty table, a small sorted table with a duplicate and both
        // key extremes, hits and misses on either side, first-match linear
        // search, unused modes, then an out-of-order key and a clear.
        queue_request(MODE_CHECK, '0, '0);
        queue_request(MODE_BSRCH, KEY_MAX, '0);
        queue_request(MODE_LSRCH, '0, KEY_MAX);
        queue_request(MODE_APPEND, '0, KEY_MAX);
        queue_request(MODE_APPEND, 48'h10, 48'h5555_5555_5555);
        queue_request(MODE_APPEND, 48'h10, 48'hAAAA_AAAA_AAAA);
        queue_request(MODE_APPEND, KEY_MAX, '0);
        queue_request(MODE_BSRCH, 48'h10, '0);
        queue_request(MODE_BSRCH, '0, '0);
        queue_request(MODE_BSRCH, KEY_MAX, '0);
        queue_request(MODE_BSRCH, 48'h8, '0);
        queue_request(MODE_BSRCH, KEY_MAX - 1'b1, '0);
        queue_request(MODE_LSRCH, 48'h10, '0);
        queue_request(MODE_LSRCH, 48'h11, '0);
        queue_request(MODE_CHECK, KEY_MAX, KEY_MAX);
        for (int m = MODE_CHECK + 1; m <= MODE_LAST; m++)
            queue_request(m[MODE_W-1:0], rand_key(), rand_key());
        queue_request(MODE_APPEND, 48'h5, 48'h1234_5678_9ABC);
        queue_request(MODE_BSRCH, 48'h5, '0);
        queue_request(MODE_LSRCH, 48'h5, '0);
        queue_request(MODE_CHECK, '0, '0);
        queue_request(MODE_CLEAR, KEY_MAX, KEY_MAX);
        queue_request(MODE_BSRCH, '0, '0);
        queue_request(MODE_APPEND, 48'h8000_0000_0000, 48'h8000_0000_0000);

        // Random: mostly build a table (usually from a clear), then search it.
        while (request_q.size() < ITEMS)
        begin
            if ($urandom_range(0, 99) < 82)
            begin
                if ($urandom_range(0, 99) < 85)
                    queue_request(MODE_CLEAR, rand_key(), rand_key());
                r = $urandom_range(0, 9);
                if (r < 4)
                    n = $urandom_range(0, 8);
                else if (r < 8)
                    n = $urandom_range(9, 40);
                else
                    n = $urandom_range(DEPTH - 4, DEPTH + 4);   // reach and overrun full
                kind = $urandom_range(0, 3);
                seq_keys.delete();
                if (kind == 0)
                    step_cap = KEY_W'($urandom_range(0, 3));    // sorted, many duplicates
                else
                    step_cap = rand_key() >> $urandom_range(7, 40);
                k = (kind < 2) ? rand_key() >> $urandom_range(1, KEY_W) : '0;
                for (int i = 0; i < n; i++)
                begin
                    if (kind < 2)
                        k = k + rand_key() % (step_cap + 1'b1);
                    else if (kind == 2)
                        k = KEY_W'($urandom_range(0, 31));      // unordered, narrow range
                    else
                        k = rand_key();
                    seq_keys.push_back(k);
                    queue_request(MODE_APPEND, k, rand_key());
                end
                nq = $urandom_range(1, 10);
                for (int i = 0; i < nq; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 50)
                        mode = MODE_BSRCH;
                    else if (r < 85)
                        mode = MODE_LSRCH;
                    else if (r < 95)
                        mode = MODE_CHECK;
                    else
                        mode = MODE_W'($urandom_range(MODE_CHECK + 1, MODE_LAST));
                    queue_request(mode, probe_key(), rand_key());
                end
            end
            else
            begin
                // noise: any mode, any content
                nq = $urandom_range(1, 6);
                for (int i = 0; i < nq; i++)
                    queue_request(MODE_W'($urandom_range(0, MODE_LAST)),
                                  $urandom_range(0, 1) ? probe_key() : rand_key(),
                                  rand_key());
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to be taken, every result to arrive, then drain.
        while (request_q.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("** sorted_key_table_search_unit: PASSED **");
        else
            $display("** sorted_key_table_search_unit: FAILED **");
        $finish;
    end

    // Give up well past the slowest legal run.
    initial
    begin
        #8000000;
        $display("** sorted_key_table_search_unit: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/skts_pkg.sv
rtl/skts_ram.sv
rtl/skts_ctrl.sv
rtl/skts_dp.sv
rtl/sorted_key_table_search_unit.sv
tb/tb.sv
